[hdl/afgsc_pkg.sv]
package afgsc_pkg;

    // field widths fixed by the interface
    localparam int SAMPLE_W    = 16;
    localparam int GAIN_W      = 16;
    localparam int THRESH_W    = 16;
    localparam int FRAME_LEN_W = 20;
    localparam int DEST_W      = 2;
    localparam int CLASS_W     = 3;
    localparam int INDEX_OUT_W = 16;
    localparam int ENERGY_W    = 50;
    localparam int CFG_DATA_W  = 20;
    localparam int CFG_INDEX_W = 2;

    // default sizing of the stateful counters
    localparam int COUNT_BITS_DEFAULT = 20;
    localparam int INDEX_BITS_DEFAULT = 16;

    // request queue between classifier front and accumulator back
    localparam int QUEUE_DEPTH = 4;

    // saturation limits of the amplified sample
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_GAIN        = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_LEN   = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DESTINATION = 2'd3;

    // register reset values
    localparam logic [GAIN_W-1:0]      GAIN_RESET      = 16'd16;
    localparam logic [THRESH_W-1:0]    THRESH_RESET    = 16'd220;
    localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_RESET = 20'd66150;
    localparam logic [DEST_W-1:0]      DEST_RESET      = 2'd0;

    // class codes
    localparam int NUM_CLASSES = 5;
    localparam logic [CLASS_W-1:0] CLASS_SILENCE = 3'd0;
    localparam logic [CLASS_W-1:0] CLASS_OTHER   = 3'd4;
    localparam logic [DEST_W-1:0]  DEST_OTHER    = 2'd0;

endpackage

[hdl/afgsc_front.sv]
module afgsc_front
    import afgsc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT,
    parameter int ITEM_W     = SAMPLE_W + 1 + COUNT_BITS + 1
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_W-1:0]    sample_in,
    input  logic                          first_of_packet,
    input  logic [GAIN_W-1:0]             gain,
    input  logic [FRAME_LEN_W-1:0]        frame_length,
    input  logic                          queue_full,
    output logic                          push,
    output logic [ITEM_W-1:0]             push_data
);

    localparam int NEXT_W = COUNT_BITS + 1;
    localparam int CMP_W  = (NEXT_W > FRAME_LEN_W) ? NEXT_W : FRAME_LEN_W;
    localparam int PROD_W = SAMPLE_W + GAIN_W + 1;

    logic [COUNT_BITS-1:0]     count_reg, count_next;
    logic                      dropping_reg, dropping_next;
    logic                      accept;
    logic                      take;
    logic [NEXT_W-1:0]         next_count;
    logic                      frame_end;
    logic signed [PROD_W-1:0]  product;
    logic signed [SAMPLE_W-1:0] amp;

    // request handshake: stall only on a full queue
    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;
    assign take     = accept && (!dropping_reg || first_of_packet);

    // frame boundary from the sample count
    assign next_count = {1'b0, count_reg} + NEXT_W'(1);
    assign frame_end  = (CMP_W'(next_count) >= CMP_W'(frame_length)) || next_count[COUNT_BITS];

    // gain and saturation
    assign product = sample_in * $signed({1'b0, gain});

    always_comb
    begin
        if (product > PROD_W'(SAMPLE_MAX))
            amp = SAMPLE_MAX;
        else if (product < PROD_W'(SAMPLE_MIN))
            amp = SAMPLE_MIN;
        else
            amp = product[SAMPLE_W-1:0];
    end

    // count and packet drop state
    always_comb
    begin
        count_next    = count_reg;
        dropping_next = dropping_reg;
        if (accept && dropping_reg && first_of_packet)
            dropping_next = 1'b0;
        if (take)
        begin
            if (frame_end)
            begin
                count_next    = '0;
                dropping_next = 1'b1;
            end
            else
            begin
                count_next = next_count[COUNT_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            dropping_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            dropping_reg <= dropping_next;
        end
    end

    assign push      = take;
    assign push_data = {amp, frame_end, next_count};

endmodule

[hdl/afgsc_queue.sv]
module afgsc_queue
    import afgsc_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full || pop)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue read while empty");

endmodule

[hdl/afgsc_back.sv]
module afgsc_back
    import afgsc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT,
    parameter int INDEX_BITS = INDEX_BITS_DEFAULT,
    parameter int ITEM_W     = SAMPLE_W + 1 + COUNT_BITS + 1
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  logic [ITEM_W-1:0]           q_data,
    output logic                        pop,
    input  logic [THRESH_W-1:0]         silence_threshold,
    input  logic [DEST_W-1:0]           destination,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [SAMPLE_W-1:0]  amplified_sample,
    output logic                        frame_last,
    output logic [CLASS_W-1:0]          frame_class,
    output logic [INDEX_OUT_W-1:0]      class_index,
    output logic [ENERGY_W-1:0]         frame_energy
);

    localparam int N_W       = COUNT_BITS + 1;
    localparam int SQ_W      = 2 * SAMPLE_W - 1;
    localparam int TSQ_W     = 2 * THRESH_W;
    localparam int LIMIT_W   = TSQ_W + N_W;
    localparam int IDX_EXT_W = (INDEX_BITS > INDEX_OUT_W) ? INDEX_BITS : INDEX_OUT_W;

    logic                         advance;
    logic signed [SAMPLE_W-1:0]   q_amp;
    logic                         q_last;
    logic [N_W-1:0]               q_n;
    logic signed [2*SAMPLE_W-1:0] q_sq;

    logic [TSQ_W-1:0]             thr_sq_reg;
    logic                         s1_valid_reg;
    logic signed [SAMPLE_W-1:0]   s1_amp_reg;
    logic                         s1_last_reg;
    logic [SQ_W-1:0]              s1_sq_reg;
    logic [LIMIT_W-1:0]           s1_limit_reg;

    logic [ENERGY_W-1:0]          energy_reg;
    logic [ENERGY_W:0]            energy_sum;
    logic [ENERGY_W-1:0]          energy_sat;
    logic [CLASS_W-1:0]           cls;
    logic [INDEX_BITS-1:0]        counter_reg [NUM_CLASSES];
    logic [IDX_EXT_W-1:0]         idx_ext;

    logic                         out_valid_reg;
    logic signed [SAMPLE_W-1:0]   amp_out_reg;
    logic                         last_out_reg;
    logic [CLASS_W-1:0]           class_out_reg;
    logic [INDEX_OUT_W-1:0]       index_out_reg;
    logic [ENERGY_W-1:0]          energy_out_reg;

    // the whole back pipeline moves while the output register can take a request
    assign advance = !out_valid_reg || !out_stall;
    assign pop     = advance && q_valid;

    assign q_amp = q_data[ITEM_W-1 -: SAMPLE_W];
    assign q_last = q_data[N_W];
    assign q_n   = q_data[N_W-1:0];
    assign q_sq  = q_amp * q_amp;

    // threshold squared, refreshed from the register
    always_ff @(posedge clk)
    begin
        thr_sq_reg <= silence_threshold * silence_threshold;
    end

    // stage one: square and silence limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (advance)
            s1_valid_reg <= q_valid;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_amp_reg   <= q_amp;
            s1_last_reg  <= q_last;
            s1_sq_reg    <= q_sq[SQ_W-1:0];
            s1_limit_reg <= thr_sq_reg * q_n;
        end
    end

    // saturating energy sum and classification
    assign energy_sum = {1'b0, energy_reg} + (ENERGY_W + 1)'(s1_sq_reg);
    assign energy_sat = energy_sum[ENERGY_W] ? ENERGY_MAX : energy_sum[ENERGY_W-1:0];

    always_comb
    begin
        if (LIMIT_W'(energy_sat) < s1_limit_reg)
            cls = CLASS_SILENCE;
        else if (destination == DEST_OTHER)
            cls = CLASS_OTHER;
        else
            cls = CLASS_W'(destination);
    end

    assign idx_ext = IDX_EXT_W'(counter_reg[cls]);

    // stage two: energy state, class counters and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            energy_reg    <= '0;
            for (int i = 0; i < NUM_CLASSES; i++)
                counter_reg[i] <= INDEX_BITS'(1);
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                if (s1_last_reg)
                begin
                    energy_reg       <= '0;
                    counter_reg[cls] <= counter_reg[cls] + INDEX_BITS'(1);
                end
                else
                begin
                    energy_reg <= energy_sat;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            amp_out_reg  <= s1_amp_reg;
            last_out_reg <= s1_last_reg;
            if (s1_last_reg)
            begin
                class_out_reg  <= cls;
                index_out_reg  <= idx_ext[INDEX_OUT_W-1:0];
                energy_out_reg <= energy_sat;
            end
            else
            begin
                class_out_reg  <= CLASS_SILENCE;
                index_out_reg  <= '0;
                energy_out_reg <= '0;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign amplified_sample = amp_out_reg;
    assign frame_last       = last_out_reg;
    assign frame_class      = class_out_reg;
    assign class_index      = index_out_reg;
    assign frame_energy     = energy_out_reg;

    a_energy_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_valid_reg && s1_last_reg) |=> (energy_reg == '0))
        else $error("frame energy not cleared after frame end");

    a_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> $stable(s1_valid_reg) && !$past(pop))
        else $error("back pipeline moved while output stalled");

endmodule

[hdl/audio_frame_gain_silence_classifier.sv]
// an accepted sample passes through the request queue, the stage-one registers and the output register in turn
// throughput: one sample per cycle while the output is not stalled; the front holds
// one multiplier and the back three, and the request queue holds four samples
// samples dropped after a frame end produce no result and never enter the queue
// reset: asynchronous, clears counts, energy and drop state, sets class counters to 1
// and loads the register reset values; no clearing pass is needed
module audio_frame_gain_silence_classifier
    import afgsc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT,
    parameter int INDEX_BITS = INDEX_BITS_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_INDEX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [SAMPLE_W-1:0]  sample_in,
    input  logic                        first_of_packet,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [SAMPLE_W-1:0]  amplified_sample,
    output logic                        frame_last,
    output logic [CLASS_W-1:0]          frame_class,
    output logic [INDEX_OUT_W-1:0]      class_index,
    output logic [ENERGY_W-1:0]         frame_energy
);

    localparam int ITEM_W = SAMPLE_W + 1 + COUNT_BITS + 1;

    logic [GAIN_W-1:0]      gain_reg;
    logic [THRESH_W-1:0]    thresh_reg;
    logic [FRAME_LEN_W-1:0] frame_len_reg;
    logic [DEST_W-1:0]      dest_reg;

    logic                   push;
    logic [ITEM_W-1:0]      push_data;
    logic                   pop;
    logic [ITEM_W-1:0]      pop_data;
    logic                   queue_full;
    logic                   queue_valid;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= GAIN_RESET;
            thresh_reg    <= THRESH_RESET;
            frame_len_reg <= FRAME_LEN_RESET;
            dest_reg      <= DEST_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_GAIN:        gain_reg      <= cfg_data[GAIN_W-1:0];
                REG_THRESHOLD:   thresh_reg    <= cfg_data[THRESH_W-1:0];
                REG_FRAME_LEN:   frame_len_reg <= cfg_data[FRAME_LEN_W-1:0];
                REG_DESTINATION: dest_reg      <= cfg_data[DEST_W-1:0];
                default:         dest_reg      <= dest_reg;
            endcase
        end
    end

    // gain, frame counting and packet drop
    afgsc_front #(
        .COUNT_BITS (COUNT_BITS),
        .ITEM_W     (ITEM_W)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .sample_in       (sample_in),
        .first_of_packet (first_of_packet),
        .gain            (gain_reg),
        .frame_length    (frame_len_reg),
        .queue_full      (queue_full),
        .push            (push),
        .push_data       (push_data)
    );

    // request queue
    afgsc_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (queue_full),
        .not_empty (queue_valid)
    );

    // energy, classification and output
    afgsc_back #(
        .COUNT_BITS (COUNT_BITS),
        .INDEX_BITS (INDEX_BITS),
        .ITEM_W     (ITEM_W)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_valid           (queue_valid),
        .q_data            (pop_data),
        .pop               (pop),
        .silence_threshold (thresh_reg),
        .destination       (dest_reg),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .amplified_sample  (amplified_sample),
        .frame_last        (frame_last),
        .frame_class       (frame_class),
        .class_index       (class_index),
        .frame_energy      (frame_energy)
    );

endmodule
